[rtl/fevt_pkg.sv]
// ----------------------------------------------------------------------------
// fevt_pkg: shared types and constants
// Payload structs, configuration layout and result codes for the frame
// energy voice activity trigger.
// ----------------------------------------------------------------------------
package fevt_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;   // square of a 16-bit sample fits in 31 bits
    localparam int ACC_W    = 40;
    localparam int OCNT_W   = 10;
    localparam int THR_W    = 31;
    localparam int CTR_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Result codes
    localparam logic [1:0] EV_ACTIVE = 2'd0;
    localparam logic [1:0] EV_WAKE   = 2'd1;
    localparam logic [1:0] EV_REPORT = 2'd2;
    localparam logic [1:0] EV_SILENT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT    = 2'd3;

    // Configuration reset values
    localparam logic [THR_W-1:0] THR_RST     = 31'd250000;
    localparam logic [CTR_W-1:0] TRIGGER_RST = 4'd3;
    localparam logic [CTR_W-1:0] SILENCE_RST = 4'd2;
    localparam logic [CTR_W-1:0] REPORT_RST  = 4'd10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } in_t;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [ACC_W-1:0]  energy_sum;
        logic [OCNT_W-1:0] frame_count;
    } out_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold_squared;
        logic [CTR_W-1:0] trigger_frames;
        logic [CTR_W-1:0] silence_frames;
        logic [CTR_W-1:0] report_interval;
    } cfg_t;

    // Frame queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[rtl/fevt_front.sv]
// ----------------------------------------------------------------------------
// fevt_front: sample front end
// Squares each sample, counts and accumulates the frame, and pushes one
// frame record (saturated energy sum, sample count) on the last sample.
// ----------------------------------------------------------------------------
module fevt_front #(
    parameter int FRAME_MAX = 512,
    parameter int CNT_W     = $clog2(FRAME_MAX + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  fevt_pkg::in_t                          item,
    input  fevt_pkg::q_stat_t                      q_stat,
    output logic                                   push,
    output logic [fevt_pkg::ACC_W+CNT_W-1:0]       push_data
);

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FRAME_MAX);
    localparam logic [fevt_pkg::ACC_W-1:0] ACC_MAX = '1;

    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        a_valid_reg, a_valid_next;
    logic [fevt_pkg::SQ_W-1:0]   a_sq_reg;
    logic [CNT_W-1:0]            a_cnt_reg;
    logic                        a_last_reg;
    logic [fevt_pkg::ACC_W-1:0]  acc_reg, acc_next;

    logic                        accept;
    logic                        b_fire;
    logic signed [31:0]          square;
    logic [CNT_W-1:0]            cnt_inc;
    logic                        last;
    logic [fevt_pkg::ACC_W:0]    acc_sum;
    logic [fevt_pkg::ACC_W-1:0]  acc_sat;

    // Square the sample and find the frame end
    always_comb
    begin
        square  = item.sample * item.sample;
        cnt_inc = cnt_reg + CNT_W'(1);
        last    = item.frame_end || (cnt_inc >= CNT_LIMIT);
    end

    // Stage B drains stage A unless a frame record meets a full queue
    assign b_fire     = a_valid_reg && (!a_last_reg || !q_stat.full);
    assign item_ready = !a_valid_reg || b_fire;
    assign accept     = item_valid && item_ready;

    // Saturating accumulate
    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + (fevt_pkg::ACC_W + 1)'(a_sq_reg);
        acc_sat = acc_sum[fevt_pkg::ACC_W] ? ACC_MAX : acc_sum[fevt_pkg::ACC_W-1:0];
    end

    assign push      = b_fire && a_last_reg;
    assign push_data = {acc_sat, a_cnt_reg};

    // Next state for counters and stage valid
    always_comb
    begin
        cnt_next     = cnt_reg;
        a_valid_next = a_valid_reg;
        acc_next     = acc_reg;
        if (accept)
        begin
            cnt_next = last ? '0 : cnt_inc;
        end
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            a_valid_next = 1'b0;
        end
        if (b_fire)
        begin
            acc_next = a_last_reg ? '0 : acc_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            a_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            a_valid_reg <= a_valid_next;
            acc_reg     <= acc_next;
        end
    end

    // Hold the squared sample for the accumulate stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sq_reg   <= square[fevt_pkg::SQ_W-1:0];
            a_cnt_reg  <= cnt_inc;
            a_last_reg <= last;
        end
    end

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && a_last_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after frame end");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg < CNT_LIMIT))
        else $error("sample counter reached frame limit");

endmodule

[rtl/fevt_queue.sv]
// ----------------------------------------------------------------------------
// fevt_queue: frame record queue
// Two-entry register queue between the front end and the decision stage.
// ----------------------------------------------------------------------------
module fevt_queue #(
    parameter int DATA_W = 50
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_W-1:0]    push_data,
    input  logic                 pop,
    output logic [DATA_W-1:0]    pop_data,
    output fevt_pkg::q_stat_t    q_stat
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        fill_reg, fill_next;

    assign q_stat.full  = fill_reg[1];
    assign q_stat.empty = (fill_reg == 2'd0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("push into full frame queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("pop from empty frame queue");

endmodule

[rtl/fevt_back.sv]
// ----------------------------------------------------------------------------
// fevt_back: frame decision stage
// Multiplies the threshold by the frame count, compares against the energy
// sum, updates the sustain, quiet and report counters and holds the result.
// ----------------------------------------------------------------------------
module fevt_back #(
    parameter int CNT_W = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fevt_pkg::cfg_t                     cfg,
    input  fevt_pkg::q_stat_t                  q_stat,
    input  logic [fevt_pkg::ACC_W+CNT_W-1:0]   pop_data,
    output logic                               pop,
    output logic                               res_valid,
    input  logic                               res_ready,
    output fevt_pkg::out_t                     res
);

    localparam int PROD_W = fevt_pkg::THR_W + CNT_W;
    localparam int CMP_W  = (PROD_W > fevt_pkg::ACC_W) ? PROD_W : fevt_pkg::ACC_W;
    localparam int CTR_W  = fevt_pkg::CTR_W;

    logic                        c_valid_reg, c_valid_next;
    logic [PROD_W-1:0]           c_prod_reg;
    logic [fevt_pkg::ACC_W-1:0]  c_sum_reg;
    logic [CNT_W-1:0]            c_cnt_reg;

    logic                        out_valid_reg, out_valid_next;
    fevt_pkg::out_t              out_reg, out_next;

    logic [CTR_W-1:0]            sus_reg, sus_next;
    logic [CTR_W-1:0]            quiet_reg, quiet_next;
    logic [CTR_W-1:0]            rep_reg, rep_next;

    logic                        d_fire;
    logic                        active;
    logic [CTR_W-1:0]            sus_inc;
    logic [CTR_W-1:0]            quiet_inc;
    logic [CTR_W-1:0]            rep_inc;
    logic [1:0]                  ev;

    // Decision stage moves when the output register is free or drained
    assign d_fire    = c_valid_reg && (!out_valid_reg || res_ready);
    assign pop       = !q_stat.empty && (!c_valid_reg || d_fire);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Frame decision and counter updates
    always_comb
    begin
        active    = CMP_W'(c_sum_reg) > CMP_W'(c_prod_reg);
        sus_inc   = sus_reg + CTR_W'(1);
        quiet_inc = (quiet_reg < cfg.silence_frames) ? quiet_reg + CTR_W'(1) : quiet_reg;
        rep_inc   = rep_reg + CTR_W'(1);
        sus_next   = sus_reg;
        quiet_next = quiet_reg;
        rep_next   = rep_reg;
        ev         = fevt_pkg::EV_ACTIVE;
        if (active)
        begin
            quiet_next = '0;
            if (sus_inc >= cfg.trigger_frames)
            begin
                sus_next = '0;
                ev       = fevt_pkg::EV_WAKE;
            end
            else
            begin
                sus_next = sus_inc;
                ev       = fevt_pkg::EV_ACTIVE;
            end
        end
        else
        begin
            quiet_next = quiet_inc;
            if (quiet_inc >= cfg.silence_frames)
            begin
                sus_next = '0;
            end
            if (rep_inc >= cfg.report_interval)
            begin
                rep_next = '0;
                ev       = fevt_pkg::EV_REPORT;
            end
            else
            begin
                rep_next = rep_inc;
                ev       = fevt_pkg::EV_SILENT;
            end
        end
        out_next.event_res   = ev;
        out_next.energy_sum  = c_sum_reg;
        out_next.frame_count = fevt_pkg::OCNT_W'(c_cnt_reg);
    end

    // Stage and output valid flags
    always_comb
    begin
        c_valid_next   = c_valid_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            c_valid_next = 1'b1;
        end
        else if (d_fire)
        begin
            c_valid_next = 1'b0;
        end
        if (d_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            sus_reg       <= '0;
            quiet_reg     <= '0;
            rep_reg       <= '0;
        end
        else
        begin
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
            if (d_fire)
            begin
                sus_reg   <= sus_next;
                quiet_reg <= quiet_next;
                rep_reg   <= rep_next;
            end
        end
    end

    // Register the threshold product and the frame record
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            c_prod_reg <= PROD_W'(cfg.threshold_squared) * PROD_W'(pop_data[CNT_W-1:0]);
            c_sum_reg  <= pop_data[fevt_pkg::ACC_W+CNT_W-1:CNT_W];
            c_cnt_reg  <= pop_data[CNT_W-1:0];
        end
        if (d_fire)
        begin
            out_reg <= out_next;
        end
    end

    a_wake_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (d_fire && (ev == fevt_pkg::EV_WAKE)) |=> (sus_reg == '0))
        else $error("sustain counter not cleared on wake");

    a_active_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (d_fire && active) |=> (quiet_reg == '0))
        else $error("quiet counter not cleared on active frame");

endmodule

[rtl/frame_energy_vad_trigger.sv]
// ----------------------------------------------------------------------------
// frame_energy_vad_trigger: frame energy voice activity trigger
// Accumulates per-frame sample energy and emits one event per frame.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) takes one signed 16-bit sample
//   per request with a frame_end mark; a frame also closes on its FRAME_MAX-th
//   sample. res channel (res_valid/res_ready/res) gives one result per frame:
//   event code, saturated energy sum and sample count.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   write only while no frame is in flight.
// Throughput: one sample per cycle unless a finished frame meets a full queue,
//   and one frame result per cycle for one-sample frames while res_ready stays
//   high; set by the single square-accumulate in the front end and the single
//   compare-and-update in the decision stage. Path: the last sample is
//   accumulated and pushed, popped with the threshold product, then decided.
// Reset: counters, accumulator and queue clear; registers take their
//   defaults. A stalled receiver fills the output register, the decision stage
//   and the two-entry frame queue; samples keep flowing until a finished frame
//   meets a full queue.
// ----------------------------------------------------------------------------
module frame_energy_vad_trigger #(
    parameter int FRAME_MAX = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  fevt_pkg::in_t                       item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output fevt_pkg::out_t                      res,
    input  logic                                cfg_we,
    input  logic [fevt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fevt_pkg::THR_W-1:0]          cfg_data
);

    localparam int CNT_W = $clog2(FRAME_MAX + 1);
    localparam int REC_W = fevt_pkg::ACC_W + CNT_W;

    fevt_pkg::cfg_t    cfg_reg, cfg_next;
    fevt_pkg::q_stat_t q_stat;
    logic              push;
    logic [REC_W-1:0]  push_data;
    logic              pop;
    logic [REC_W-1:0]  pop_data;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fevt_pkg::CFG_THRESHOLD: cfg_next.threshold_squared = cfg_data;
                fevt_pkg::CFG_TRIGGER:
                    cfg_next.trigger_frames = cfg_data[fevt_pkg::CTR_W-1:0];
                fevt_pkg::CFG_SILENCE:
                    cfg_next.silence_frames = cfg_data[fevt_pkg::CTR_W-1:0];
                fevt_pkg::CFG_REPORT:
                    cfg_next.report_interval = cfg_data[fevt_pkg::CTR_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_squared <= fevt_pkg::THR_RST;
            cfg_reg.trigger_frames    <= fevt_pkg::TRIGGER_RST;
            cfg_reg.silence_frames    <= fevt_pkg::SILENCE_RST;
            cfg_reg.report_interval   <= fevt_pkg::REPORT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fevt_front #(
        .FRAME_MAX (FRAME_MAX),
        .CNT_W     (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    fevt_queue #(
        .DATA_W (REC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    fevt_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
